>>> hdl/bmmc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bmmc_pkg
// shared result kinds for the bipartite matching / vertex cover core
// ---------------------------------------------------------------------------
package bmmc_pkg;

    typedef enum logic [1:0] {
        KIND_PARTNER    = 2'd0,
        KIND_COVER_LEFT = 2'd1,
        KIND_COVER_RIGHT = 2'd2,
        KIND_SUMMARY    = 2'd3
    } kind_t;

endpackage : bmmc_pkg
`default_nettype wire

>>> hdl/bipartite_max_matching_cover_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bipartite_max_matching_cover_core
// maximum bipartite matching (augmenting-path search) plus minimum vertex cover
// ---------------------------------------------------------------------------
// load: one edge transfer per cycle into the adjacency memory
// solve: starts on the last transfer; one adjacency memory read per step, each
//   entry addressed in a read state (_R) and checked in a check state (_C),
//   plus root, seed and result sweeps
// results leave through an output register, at most one per cycle; input is
//   stalled from the last transfer until the summary enters the output register
// reset: asynchronous, clears mates, degrees and control, counts back to 16;
//   the adjacency memory and search stack are not reset
module bipartite_max_matching_cover_core #(
    parameter int MAX_LEFT   = 16,
    parameter int MAX_RIGHT  = 16,
    parameter int MAX_DEGREE = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write,
    input  wire logic [0:0] cfg_index,
    input  wire logic [4:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [3:0] left_vertex,
    input  wire logic [3:0] right_vertex,
    input  wire logic       has_edge,
    input  wire logic       last,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      kind,
    output logic [3:0]      vertex,
    output logic [4:0]      partner,
    output logic [4:0]      match_count,
    output logic            dropped,
    output logic            end_of_run
);

    // index widths derived from the limits
    localparam int LW = (MAX_LEFT > 1) ? $clog2(MAX_LEFT) : 1;
    localparam int RW = (MAX_RIGHT > 1) ? $clog2(MAX_RIGHT) : 1;
    localparam int DW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int DCW = $clog2(MAX_DEGREE + 1);
    localparam int LCW = $clog2(MAX_LEFT + 1);
    localparam int RCW = $clog2(MAX_RIGHT + 1);
    localparam int AW = LW + DW;

    // one-hot sequencer
    typedef enum logic [15:0] {
        S_LOAD   = 16'h0001,
        S_INIT   = 16'h0002,  // clear mates and stamps
        S_ROOT   = 16'h0004,  // next root of the augment loop
        S_FREE_R = 16'h0008,  // read adjacency for the free-neighbour scan
        S_FREE_C = 16'h0010,  // check read data
        S_DFS_R  = 16'h0020,  // read top frame's current entry
        S_DFS_C  = 16'h0040,
        S_UNW_R  = 16'h0080,  // augment along the stack
        S_UNW_C  = 16'h0100,
        S_CV_CLR = 16'h0200,  // clear stamps; S_CV_POP then seeds the stack with free lefts
        S_CV_POP = 16'h0400,
        S_CV_R   = 16'h0800,
        S_CV_C   = 16'h1000,
        S_RC_R   = 16'h2000,  // mark right cover
        S_RC_C   = 16'h4000,
        S_EMIT   = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    // memories
    logic [RW-1:0] adj_mem [MAX_LEFT*MAX_DEGREE];
    logic [AW-1:0] adj_raddr;
    logic [RW-1:0] adj_q_reg;
    logic [LW-1:0] stk_v [MAX_LEFT];
    logic [DCW-1:0] stk_p [MAX_LEFT];

    // small per-vertex register files
    logic [DCW-1:0] degree_reg [MAX_LEFT];
    logic [RCW-1:0] lmate_reg [MAX_LEFT];     // MAX_RIGHT = unmatched
    logic [LCW-1:0] rmate_reg [MAX_RIGHT];    // MAX_LEFT = unmatched
    logic [LCW-1:0] stamp_reg [MAX_LEFT];
    logic           rcov_reg [MAX_RIGHT];

    logic [4:0]     left_count_reg, right_count_reg;
    logic [LCW-1:0] pair_total_reg;
    logic           drop_reg;

    // sequencer working registers
    logic [LCW-1:0] i_reg;        // root / sweep index
    logic [LW-1:0]  v_reg;        // vertex under scan
    logic [DCW-1:0] j_reg;        // adjacency position
    logic [LCW-1:0] sp_reg;       // stack depth
    logic [LCW-1:0] stamp_cur_reg;
    logic [1:0]     emit_ph_reg;  // 0 partners, 1 cover left, 2 cover right, 3 summary

    // output register
    logic       ov_reg;
    logic [1:0] kind_reg;
    logic [3:0] vertex_reg;
    logic [4:0] partner_reg, mcount_reg;
    logic       dropped_reg, eor_reg;

    // used counts, clipped to the maxima
    logic [LCW-1:0] nl;
    logic [RCW-1:0] nr;
    assign nl = (32'(left_count_reg) > MAX_LEFT) ? LCW'(MAX_LEFT) : LCW'(left_count_reg);
    assign nr = (32'(right_count_reg) > MAX_RIGHT) ? RCW'(MAX_RIGHT) : RCW'(right_count_reg);

    logic in_xfer, out_free;
    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !ov_reg || !out_stall;
    assign in_stall = (state_reg != S_LOAD);

    assign out_valid   = ov_reg;
    assign kind        = kind_reg;
    assign vertex      = vertex_reg;
    assign partner     = partner_reg;
    assign match_count = mcount_reg;
    assign dropped     = dropped_reg;
    assign end_of_run  = eor_reg;

    // load path
    logic          edge_ok;
    logic [LW-1:0] lv;
    logic [RW-1:0] rv;
    assign lv = LW'(left_vertex);
    assign rv = RW'(right_vertex);
    assign edge_ok = (32'(left_vertex) < 32'(nl)) && (32'(right_vertex) < 32'(nr))
                     && (32'(degree_reg[lv]) < MAX_DEGREE);

    // top of stack and read data decoding
    logic [LW-1:0]  top_v;
    logic [DCW-1:0] top_p;
    logic [LCW-1:0] sp_m1;
    assign sp_m1 = sp_reg - LCW'(1);
    assign top_v = stk_v[sp_m1[LW-1:0]];
    assign top_p = stk_p[sp_m1[LW-1:0]];

    logic           u_ok;
    logic [LCW-1:0] w;
    logic [LW-1:0]  wi;
    assign u_ok = (32'(adj_q_reg) < 32'(nr));
    assign w    = rmate_reg[adj_q_reg];
    assign wi   = w[LW-1:0];

    logic [DCW-1:0] deg_v;
    assign deg_v = degree_reg[v_reg];

    // a result is placed in the output register this cycle
    logic emit_hit, emit_fire;
    always_comb
    begin
        case (emit_ph_reg)
            2'd0:    emit_hit = (i_reg < nl);
            2'd1:    emit_hit = (i_reg < nl) && (stamp_reg[i_reg[LW-1:0]] == '0);
            2'd2:    emit_hit = (32'(i_reg) < 32'(nr)) && rcov_reg[i_reg[RW-1:0]];
            default: emit_hit = 1'b1;
        endcase
    end
    assign emit_fire = (state_reg == S_EMIT) && out_free && emit_hit;

    // adjacency read address per state
    always_comb
    begin
        adj_raddr = {v_reg, j_reg[DW-1:0]};
        if (state_reg == S_DFS_R || state_reg == S_UNW_R)
        begin
            adj_raddr = {top_v, top_p[DW-1:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        adj_q_reg <= adj_mem[adj_raddr];
        if (state_reg == S_LOAD && in_xfer && has_edge && edge_ok)
        begin
            adj_mem[{lv, degree_reg[lv][DW-1:0]}] <= rv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_LOAD;
            left_count_reg  <= 5'd16;
            right_count_reg <= 5'd16;
            pair_total_reg  <= '0;
            drop_reg        <= 1'b0;
            i_reg           <= '0;
            v_reg           <= '0;
            j_reg           <= '0;
            sp_reg          <= '0;
            stamp_cur_reg   <= '0;
            emit_ph_reg     <= '0;
            ov_reg          <= 1'b0;
            for (int k = 0; k < MAX_LEFT; k++)
            begin
                degree_reg[k] <= '0;
                lmate_reg[k]  <= RCW'(MAX_RIGHT);
                stamp_reg[k]  <= '0;
            end
            for (int k = 0; k < MAX_RIGHT; k++)
            begin
                rmate_reg[k] <= LCW'(MAX_LEFT);
                rcov_reg[k]  <= 1'b0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == 1'b0)
                    left_count_reg <= cfg_data;
                else
                    right_count_reg <= cfg_data;
            end
            ov_reg <= emit_fire || (ov_reg && out_stall);

            case (state_reg)
                S_LOAD:
                begin
                    if (in_xfer)
                    begin
                        if (has_edge)
                        begin
                            if (edge_ok)
                                degree_reg[lv] <= degree_reg[lv] + DCW'(1);
                            else
                                drop_reg <= 1'b1;
                        end
                        if (last)
                        begin
                            i_reg     <= '0;
                            state_reg <= S_INIT;
                        end
                    end
                end
                S_INIT:
                begin
                    for (int k = 0; k < MAX_LEFT; k++)
                    begin
                        lmate_reg[k] <= RCW'(MAX_RIGHT);
                        stamp_reg[k] <= '0;
                    end
                    for (int k = 0; k < MAX_RIGHT; k++)
                    begin
                        rmate_reg[k] <= LCW'(MAX_LEFT);
                        rcov_reg[k]  <= 1'b0;
                    end
                    pair_total_reg <= '0;
                    state_reg      <= S_ROOT;
                end
                S_ROOT:
                begin
                    if (i_reg >= nl)
                    begin
                        state_reg <= S_CV_CLR;
                    end
                    else if (stamp_reg[i_reg[LW-1:0]] == pair_total_reg + LCW'(1))
                    begin
                        i_reg <= i_reg + LCW'(1);
                    end
                    else
                    begin
                        stamp_reg[i_reg[LW-1:0]] <= pair_total_reg + LCW'(1);
                        stamp_cur_reg <= pair_total_reg + LCW'(1);
                        v_reg     <= i_reg[LW-1:0];
                        j_reg     <= '0;
                        sp_reg    <= '0;
                        state_reg <= S_FREE_R;
                    end
                end
                S_FREE_R:
                begin
                    if (j_reg >= deg_v)
                    begin
                        // no free neighbour: push vertex and search deeper
                        stk_v[sp_reg[LW-1:0]] <= v_reg;
                        stk_p[sp_reg[LW-1:0]] <= '0;
                        sp_reg    <= sp_reg + LCW'(1);
                        state_reg <= S_DFS_R;
                    end
                    else
                    begin
                        state_reg <= S_FREE_C;
                    end
                end
                S_FREE_C:
                begin
                    if (u_ok && w == LCW'(MAX_LEFT))
                    begin
                        rmate_reg[adj_q_reg] <= LCW'(v_reg);
                        lmate_reg[v_reg]     <= RCW'(adj_q_reg);
                        if (sp_reg == '0)
                        begin
                            pair_total_reg <= pair_total_reg + LCW'(1);
                            i_reg          <= i_reg + LCW'(1);
                            state_reg      <= S_ROOT;
                        end
                        else
                        begin
                            state_reg <= S_UNW_R;
                        end
                    end
                    else
                    begin
                        j_reg     <= j_reg + DCW'(1);
                        state_reg <= S_FREE_R;
                    end
                end
                S_DFS_R:
                begin
                    if (sp_reg == '0)
                    begin
                        i_reg     <= i_reg + LCW'(1);
                        state_reg <= S_ROOT;
                    end
                    else if (top_p >= degree_reg[top_v])
                    begin
                        // list exhausted: pop and advance the parent frame
                        sp_reg <= sp_m1;
                        if (sp_m1 != '0)
                            stk_p[sp_m1[LW-1:0] - LW'(1)] <=
                                stk_p[sp_m1[LW-1:0] - LW'(1)] + DCW'(1);
                    end
                    else
                    begin
                        state_reg <= S_DFS_C;
                    end
                end
                S_DFS_C:
                begin
                    if (!u_ok || w >= LCW'(MAX_LEFT) || stamp_reg[wi] == stamp_cur_reg
                        || sp_reg >= LCW'(MAX_LEFT))
                    begin
                        stk_p[sp_m1[LW-1:0]] <= top_p + DCW'(1);
                        state_reg <= S_DFS_R;
                    end
                    else
                    begin
                        stamp_reg[wi] <= stamp_cur_reg;
                        v_reg         <= wi;
                        j_reg         <= '0;
                        state_reg     <= S_FREE_R;
                        // the free scan pushes wi when it fails
                    end
                end
                S_UNW_R:
                begin
                    if (sp_reg == '0)
                    begin
                        pair_total_reg <= pair_total_reg + LCW'(1);
                        i_reg          <= i_reg + LCW'(1);
                        state_reg      <= S_ROOT;
                    end
                    else
                    begin
                        state_reg <= S_UNW_C;
                    end
                end
                S_UNW_C:
                begin
                    rmate_reg[adj_q_reg] <= LCW'(top_v);
                    lmate_reg[top_v]     <= RCW'(adj_q_reg);
                    sp_reg    <= sp_m1;
                    state_reg <= S_UNW_R;
                end
                S_CV_CLR:
                begin
                    // clear stamps and restart i_reg from 0 for the seeding pass in S_CV_POP
                    if (i_reg >= nl)
                    begin
                        i_reg <= '0;
                        for (int k = 0; k < MAX_LEFT; k++)
                            stamp_reg[k] <= '0;
                        sp_reg    <= '0;
                        state_reg <= S_CV_POP;
                        emit_ph_reg <= 2'd1;
                    end
                    else
                    begin
                        i_reg <= nl;
                    end
                end
                S_CV_POP:
                begin
                    if (emit_ph_reg == 2'd1)
                    begin
                        // seeding pass
                        if (i_reg >= nl)
                        begin
                            emit_ph_reg <= 2'd0;
                        end
                        else
                        begin
                            if (lmate_reg[i_reg[LW-1:0]] == RCW'(MAX_RIGHT))
                            begin
                                stamp_reg[i_reg[LW-1:0]] <= LCW'(1);
                                stk_v[sp_reg[LW-1:0]]    <= i_reg[LW-1:0];
                                sp_reg <= sp_reg + LCW'(1);
                            end
                            i_reg <= i_reg + LCW'(1);
                        end
                    end
                    else if (sp_reg == '0)
                    begin
                        i_reg     <= '0;
                        j_reg     <= '0;
                        v_reg     <= '0;
                        state_reg <= S_RC_R;
                    end
                    else
                    begin
                        v_reg     <= top_v;
                        sp_reg    <= sp_m1;
                        j_reg     <= '0;
                        state_reg <= S_CV_R;
                    end
                end
                S_CV_R:
                begin
                    if (j_reg >= deg_v)
                        state_reg <= S_CV_POP;
                    else
                        state_reg <= S_CV_C;
                end
                S_CV_C:
                begin
                    if (u_ok && RCW'(adj_q_reg) != lmate_reg[v_reg] && w < nl
                        && stamp_reg[wi] == '0 && sp_reg < LCW'(MAX_LEFT))
                    begin
                        stamp_reg[wi]         <= LCW'(1);
                        stk_v[sp_reg[LW-1:0]] <= wi;
                        sp_reg <= sp_reg + LCW'(1);
                    end
                    j_reg     <= j_reg + DCW'(1);
                    state_reg <= S_CV_R;
                end
                S_RC_R:
                begin
                    if (i_reg >= nl)
                    begin
                        i_reg       <= '0;
                        emit_ph_reg <= 2'd0;
                        state_reg   <= S_EMIT;
                    end
                    else if (stamp_reg[i_reg[LW-1:0]] == '0
                             || lmate_reg[i_reg[LW-1:0]] == RCW'(MAX_RIGHT)
                             || j_reg >= degree_reg[i_reg[LW-1:0]])
                    begin
                        i_reg <= i_reg + LCW'(1);
                        v_reg <= LW'(i_reg + LCW'(1));
                        j_reg <= '0;
                    end
                    else
                    begin
                        state_reg <= S_RC_C;
                    end
                end
                S_RC_C:
                begin
                    if (u_ok)
                        rcov_reg[adj_q_reg] <= 1'b1;
                    j_reg     <= j_reg + DCW'(1);
                    state_reg <= S_RC_R;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        case (emit_ph_reg)
                            2'd0:
                            begin
                                if (i_reg >= nl)
                                begin
                                    i_reg <= '0;
                                    emit_ph_reg <= 2'd1;
                                end
                                else
                                begin
                                    kind_reg    <= bmmc_pkg::KIND_PARTNER;
                                    vertex_reg  <= 4'(i_reg);
                                    partner_reg <= 5'(lmate_reg[i_reg[LW-1:0]]);
                                    mcount_reg  <= '0;
                                    dropped_reg <= 1'b0;
                                    eor_reg     <= 1'b0;
                                    i_reg <= i_reg + LCW'(1);
                                end
                            end
                            2'd1:
                            begin
                                if (i_reg >= nl)
                                begin
                                    i_reg <= '0;
                                    emit_ph_reg <= 2'd2;
                                end
                                else
                                begin
                                    if (stamp_reg[i_reg[LW-1:0]] == '0)
                                    begin
                                        kind_reg    <= bmmc_pkg::KIND_COVER_LEFT;
                                        vertex_reg  <= 4'(i_reg);
                                        partner_reg <= '0;
                                        mcount_reg  <= '0;
                                        dropped_reg <= 1'b0;
                                        eor_reg     <= 1'b0;
                                    end
                                    i_reg <= i_reg + LCW'(1);
                                end
                            end
                            2'd2:
                            begin
                                if (32'(i_reg) >= 32'(nr))
                                begin
                                    emit_ph_reg <= 2'd3;
                                end
                                else
                                begin
                                    if (rcov_reg[i_reg[RW-1:0]])
                                    begin
                                        kind_reg    <= bmmc_pkg::KIND_COVER_RIGHT;
                                        vertex_reg  <= 4'(i_reg);
                                        partner_reg <= '0;
                                        mcount_reg  <= '0;
                                        dropped_reg <= 1'b0;
                                        eor_reg     <= 1'b0;
                                    end
                                    i_reg <= i_reg + LCW'(1);
                                end
                            end
                            default:
                            begin
                                kind_reg    <= bmmc_pkg::KIND_SUMMARY;
                                vertex_reg  <= '0;
                                partner_reg <= '0;
                                mcount_reg  <= 5'(pair_total_reg);
                                dropped_reg <= drop_reg;
                                eor_reg     <= 1'b1;
                                drop_reg    <= 1'b0;
                                for (int k = 0; k < MAX_LEFT; k++)
                                    degree_reg[k] <= '0;
                                state_reg <= S_LOAD;
                            end
                        endcase
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

endmodule : bipartite_max_matching_cover_core
`default_nettype wire

>>> hdl/bmmc_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bmmc_checker
// port-level checks for the matching core, bound to the core module
// ---------------------------------------------------------------------------
module bmmc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       last,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [1:0] kind,
    input wire logic       end_of_run
);

    // end of run only on the summary
    a_eor_summary: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_run |-> kind == bmmc_pkg::KIND_SUMMARY)
        else $error("end_of_run on non-summary result");

    // summary always closes the run
    a_summary_eor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == bmmc_pkg::KIND_SUMMARY |-> end_of_run)
        else $error("summary without end_of_run");

    // input stalls after the last transfer
    a_stall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last |=> in_stall)
        else $error("input not stalled during solve");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind))
        else $error("stalled result changed");

endmodule : bmmc_checker

bind bipartite_max_matching_cover_core bmmc_checker u_bmmc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .last       (last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .end_of_run (end_of_run)
);
`default_nettype wire

>>> tb/sv/bipartite_max_matching_cover_core_tb.sv
// ---------------------------------------------------------------------------
// bipartite_max_matching_cover_core_tb
// loads random and directed bipartite graphs edge by edge, predicts the
// maximum matching and vertex cover in the bench and checks every result
// ---------------------------------------------------------------------------
module bipartite_max_matching_cover_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NL_MAX = 16;
    localparam int NR_MAX = 16;
    localparam int DEG_MAX = 16;
    localparam logic [0:0] REG_LEFT_COUNT = 1'b0;
    localparam logic [0:0] REG_RIGHT_COUNT = 1'b1;

    typedef struct packed {
        bmmc_pkg::kind_t kind;
        logic [3:0] vertex;
        logic [4:0] partner;
        logic [4:0] match_count;
        logic       dropped;
        logic       end_of_run;
    } cover_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [0:0] cfg_index = '0;
    logic [4:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [3:0] left_vertex = '0;
    logic [3:0] right_vertex = '0;
    logic has_edge = 1'b0;
    logic last = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [1:0] kind;
    logic [3:0] vertex;
    logic [4:0] partner;
    logic [4:0] match_count;
    logic dropped;
    logic end_of_run;

    // predictor state
    logic [3:0] adj [NL_MAX][DEG_MAX];
    int unsigned deg [NL_MAX];
    int unsigned lmate [NL_MAX];
    int unsigned rmate [NR_MAX];
    int unsigned stamp [NL_MAX];
    int unsigned stk_v [NL_MAX];
    int unsigned stk_p [NL_MAX];
    bit rcover [NR_MAX];
    bit drop_seen;
    int unsigned pairs;
    int unsigned left_cfg = 16;
    int unsigned right_cfg = 16;

    cover_result_t expected_results [$];
    int mismatches = 0;
    bit no_idle = 1'b0;

    always #1 clk = ~clk;

    bipartite_max_matching_cover_core DUT (.*);

    function automatic int unsigned nl_used();
        return left_cfg > NL_MAX ? NL_MAX : left_cfg;
    endfunction

    function automatic int unsigned nr_used();
        return right_cfg > NR_MAX ? NR_MAX : right_cfg;
    endfunction

    function automatic bit grab_free(int unsigned v, int unsigned nr);
        int unsigned u;
        for (int i = 0; i < deg[v]; i++)
        begin
            u = adj[v][i];
            if (u < nr && rmate[u] == NL_MAX)
            begin
                rmate[u] = v;
                lmate[v] = u;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // kuhn search from one root with an explicit stack
    function automatic bit find_augmenting(int unsigned root, int unsigned nr, int unsigned st);
        int unsigned sp, v, p, u, w;
        if (stamp[root] == st)
            return 1'b0;
        stamp[root] = st;
        if (grab_free(root, nr))
            return 1'b1;
        stk_v[0] = root;
        stk_p[0] = 0;
        sp = 1;
        while (sp > 0)
        begin
            v = stk_v[sp-1];
            p = stk_p[sp-1];
            if (p >= deg[v])
            begin
                sp--;
                if (sp > 0)
                    stk_p[sp-1]++;
                continue;
            end
            u = adj[v][p];
            if (u >= nr)
            begin
                stk_p[sp-1]++;
                continue;
            end
            w = rmate[u];
            if (w >= NL_MAX || stamp[w] == st || sp >= NL_MAX)
            begin
                stk_p[sp-1]++;
                continue;
            end
            stamp[w] = st;
            if (grab_free(w, nr))
            begin
                while (sp > 0)
                begin
                    sp--;
                    v = stk_v[sp];
                    u = adj[v][stk_p[sp]];
                    rmate[u] = v;
                    lmate[v] = u;
                end
                return 1'b1;
            end
            stk_v[sp] = w;
            stk_p[sp] = 0;
            sp++;
        end
        return 1'b0;
    endfunction

    function automatic void push_result(bmmc_pkg::kind_t k, int unsigned v, int unsigned p,
                                        int unsigned c, bit d, bit e);
        cover_result_t r;
        r.kind = k;
        r.vertex = v[3:0];
        r.partner = p[4:0];
        r.match_count = c[4:0];
        r.dropped = d;
        r.end_of_run = e;
        expected_results.insert(expected_results.size(), r);
    endfunction

    // matching, then the cover from alternating paths
    function automatic void solve_graph();
        int unsigned nl, nr, sp, v, u, w;
        nl = nl_used();
        nr = nr_used();
        sp = 0;
        for (int i = 0; i < NL_MAX; i++) begin lmate[i] = NR_MAX; stamp[i] = 0; end
        for (int i = 0; i < NR_MAX; i++) begin rmate[i] = NL_MAX; rcover[i] = 0; end
        pairs = 0;
        for (int i = 0; i < nl; i++)
            if (find_augmenting(i, nr, pairs + 1))
                pairs++;
        for (int i = 0; i < NL_MAX; i++)
            stamp[i] = 0;
        for (int i = 0; i < nl; i++)
            if (lmate[i] == NR_MAX && sp < NL_MAX)
            begin
                stamp[i] = 1;
                stk_v[sp++] = i;
            end
        while (sp > 0)
        begin
            v = stk_v[--sp];
            for (int j = 0; j < deg[v]; j++)
            begin
                u = adj[v][j];
                if (u >= nr || u == lmate[v])
                    continue;
                w = rmate[u];
                if (w < nl && stamp[w] == 0 && sp < NL_MAX)
                begin
                    stamp[w] = 1;
                    stk_v[sp++] = w;
                end
            end
        end
        for (int i = 0; i < nl; i++)
            if (stamp[i] != 0 && lmate[i] != NR_MAX)
                for (int j = 0; j < deg[i]; j++)
                    if (adj[i][j] < nr)
                        rcover[adj[i][j]] = 1;
        for (int i = 0; i < nl; i++)
            push_result(bmmc_pkg::KIND_PARTNER, i, lmate[i], 0, 0, 0);
        for (int i = 0; i < nl; i++)
            if (stamp[i] == 0)
                push_result(bmmc_pkg::KIND_COVER_LEFT, i, 0, 0, 0, 0);
        for (int i = 0; i < nr; i++)
            if (rcover[i])
                push_result(bmmc_pkg::KIND_COVER_RIGHT, i, 0, 0, 0, 0);
        push_result(bmmc_pkg::KIND_SUMMARY, 0, 0, pairs, drop_seen, 1);
        for (int i = 0; i < NL_MAX; i++)
            deg[i] = 0;
        drop_seen = 0;
    endfunction

    function automatic void predict_edge(int unsigned lv, int unsigned rv, bit he, bit lst);
        if (he)
        begin
            if (lv >= nl_used() || rv >= nr_used() || deg[lv] >= DEG_MAX)
                drop_seen = 1;
            else
                adj[lv][deg[lv]++] = rv[3:0];
        end
        if (lst)
            solve_graph();
    endfunction

    // one edge transfer, with random idle cycles before it; valid stays high
    // afterwards until the next item or idle cycle replaces it
    task automatic send_edge(int unsigned lv, int unsigned rv, bit he, bit lst);
        while (!no_idle && $urandom_range(99) < 13)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        left_vertex <= lv[3:0];
        right_vertex <= rv[3:0];
        has_edge <= he;
        last <= lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_edge(lv, rv, he, lst);
    endtask

    // let the solve drain before touching the counts
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_counts(int unsigned lc, int unsigned rc);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= REG_LEFT_COUNT;
        cfg_data <= lc[4:0];
        @(posedge clk);
        cfg_index <= REG_RIGHT_COUNT;
        cfg_data <= rc[4:0];
        @(posedge clk);
        cfg_write <= 1'b0;
        left_cfg = lc;
        right_cfg = rc;
    endtask

    // a graph of n random edges, mostly in range
    task automatic send_graph(int n, int unsigned lspan, int unsigned rspan);
        for (int i = 0; i < n; i++)
            send_edge($urandom_range(lspan - 1), $urandom_range(rspan - 1),
                      $urandom_range(99) < 92, i == n - 1);
    endtask

    task automatic test_directed();
        // empty graph, then a single edge
        send_edge(0, 0, 0, 1);
        send_edge(15, 15, 1, 1);
        // path needing an augmenting walk: 0-{0,1}, 1-{0}
        send_edge(0, 0, 1, 0);
        send_edge(0, 1, 1, 0);
        send_edge(1, 0, 1, 1);
        // degree overflow on vertex 3
        for (int i = 0; i < 17; i++)
            send_edge(3, i % 16, 1, i == 16);
    endtask

    task automatic test_counts();
        write_counts(4, 3);
        send_edge(5, 1, 1, 0);          // left out of range
        send_edge(1, 7, 1, 0);          // right out of range
        send_edge(2, 2, 1, 1);
        write_counts(0, 0);             // no vertices at all
        send_edge(0, 0, 1, 1);
        write_counts(31, 20);           // above maximum acts as maximum
        send_edge(10, 12, 1, 1);
        // counts lowered while loading
        write_counts(16, 16);
        send_edge(2, 14, 1, 0);
        send_edge(2, 1, 1, 0);
        write_counts(3, 8);
        send_edge(0, 0, 1, 1);
    endtask

    task automatic test_random();
        int unsigned lc, rc;
        for (int g = 0; g < 22; g++)
        begin
            if (g % 5 == 0)
            begin
                lc = (g == 0) ? 16 : $urandom_range(1, 16);
                rc = (g == 5) ? 1 : $urandom_range(1, 16);
                write_counts(lc, rc);
            end
            no_idle = (g >= 8 && g < 11);
            send_graph($urandom_range(3, 14), 16, 16);
        end
        no_idle = 1'b0;
    endtask

    // result checker with random back-pressure
    always @(posedge clk)
    begin
        cover_result_t got, want;
        if (out_valid && !out_stall)
        begin
            got.kind = bmmc_pkg::kind_t'(kind);
            got.vertex = vertex;
            got.partner = partner;
            got.match_count = match_count;
            got.dropped = dropped;
            got.end_of_run = end_of_run;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p got %p", want, got);
                end
            end
        end
        out_stall <= !no_idle && ($urandom_range(99) < 13);
    end

    initial
    begin
        for (int i = 0; i < NL_MAX; i++) deg[i] = 0;
        drop_seen = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_counts();
        test_random();
        wait_idle();
        if (mismatches == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
